// File: design/cpwm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cpwm_pkg;

   localparam int COUNTER_WIDTH_DEFAULT = 16;
   localparam int PAIR_COUNT_DEFAULT    = 4;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int TOP_WIDTH       = 16;
   localparam int PERCENT_WIDTH   = 7;
   localparam int MASK_WIDTH      = 4;
   localparam int LEVEL_PAIRS     = 4;
   localparam int LEVEL_WIDTH     = 2 * LEVEL_PAIRS;
   localparam int OUT_CNT_WIDTH   = 16;
   localparam int DIVIDER_WIDTH   = 7;
   localparam int PRESCALE_WIDTH  = 3;
   localparam int DT_CODE_WIDTH   = 2;
   localparam int DT_VALUE_WIDTH  = 6;
   localparam int DEAD_WIDTH      = 10;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PERIOD_TOP        = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COUNTER_START     = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CLOCK_PRESCALE    = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEADTIME_PRESCALE = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEADTIME_VALUE    = 3'd4;

   localparam logic [TOP_WIDTH-1:0]      PERIOD_TOP_RESET    = 16'd170;
   localparam logic [TOP_WIDTH-1:0]      COUNTER_START_RESET = 16'd0;
   localparam logic [PRESCALE_WIDTH-1:0] CLOCK_PRESCALE_RESET = 3'd0;
   localparam logic [DT_CODE_WIDTH-1:0]  DT_PRESCALE_RESET   = 2'd2;
   localparam logic [DT_VALUE_WIDTH-1:0] DT_VALUE_RESET      = 6'd3;

   localparam logic [PERCENT_WIDTH-1:0] DUTY_MAX = 7'd100;

   // Division by 100 as a multiply by a rounded-up reciprocal, exact below 2^23.
   localparam int PRODUCT_WIDTH = PERCENT_WIDTH + TOP_WIDTH;
   localparam int RECIP_WIDTH   = 24;
   localparam int RECIP_SHIFT   = 30;
   localparam int QUOT_WIDTH    = PRODUCT_WIDTH + RECIP_WIDTH;
   localparam logic [RECIP_WIDTH-1:0] DIV100_RECIP = 24'd10737419;

   localparam logic [DT_CODE_WIDTH-1:0] DT_CODE_X4  = 2'd2;
   localparam logic [DT_CODE_WIDTH-1:0] DT_CODE_X16 = 2'd3;

   typedef struct packed {
      logic                  tick;
      logic                  reload;
      logic [DEAD_WIDTH-1:0] dead_ticks;
   } pair_ctrl_type;

   function automatic logic [DEAD_WIDTH-1:0] dead_ticks_of(
      input logic [DT_CODE_WIDTH-1:0]  code,
      input logic [DT_VALUE_WIDTH-1:0] value
   );
      logic [DEAD_WIDTH-1:0] base;
      base = DEAD_WIDTH'(value);
      case (code)
         DT_CODE_X4:  dead_ticks_of = base << 2;
         DT_CODE_X16: dead_ticks_of = base << 4;
         default:     dead_ticks_of = base;
      endcase
   endfunction

endpackage

`default_nettype wire

// File: design/cpwm_pair.sv
`timescale 1ns / 1ps
`default_nettype none

module cpwm_pair #(
   parameter int COUNTER_WIDTH = cpwm_pkg::COUNTER_WIDTH_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire cpwm_pkg::pair_ctrl_type      ctrl,
   input  wire logic                         write_en,
   input  wire logic [COUNTER_WIDTH-1:0]     write_match,
   input  wire logic [COUNTER_WIDTH-1:0]     counter_in,
   output logic      [1:0]                   level_in
);
   import cpwm_pkg::*;

   logic [COUNTER_WIDTH-1:0] active_ff, active_in;
   logic [COUNTER_WIDTH-1:0] shadow_ff, shadow_in;
   logic                     raw_ff, raw_in;
   logic [DEAD_WIDTH-1:0]    dead_ff, dead_in;

   always_comb begin
      shadow_in = write_en ? write_match : shadow_ff;
      active_in = (ctrl.tick && ctrl.reload) ? shadow_ff : active_ff;
      raw_in    = raw_ff;
      dead_in   = dead_ff;
      if (ctrl.tick) begin
         raw_in = (counter_in >= active_in);
         if (raw_in != raw_ff) begin
            dead_in = ctrl.dead_ticks;
         end else if (dead_ff != '0) begin
            dead_in = dead_ff - DEAD_WIDTH'(1);
         end
      end
      if (dead_in != '0) begin
         level_in = 2'b00;
      end else begin
         level_in = {~raw_in, raw_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         shadow_ff <= '0;
         raw_ff    <= 1'b0;
         dead_ff   <= '0;
      end else begin
         active_ff <= active_in;
         shadow_ff <= shadow_in;
         raw_ff    <= raw_in;
         dead_ff   <= dead_in;
      end
   end

endmodule

`default_nettype wire

// File: design/complementary_pwm_deadtime_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Complementary edge-aligned PWM generator with dead-time insertion. Each request beat is
// either one timer tick or one duty write, and every beat yields exactly one response
// beat carrying the channel levels, the period counter and the reload flag after that
// beat. One beat is accepted every clock cycle unless the response side stalls; the
// response passes through the input register, which holds the beat with percent times
// top already formed, and then the response register, which the state update pass fills.
// That single pass per beat sets the one-beat-per-cycle rate. Configuration writes are
// accepted at any time but must only be issued while no beat is in flight. No clearing
// pass follows reset.
module complementary_pwm_deadtime_top #(
   parameter int COUNTER_WIDTH = cpwm_pkg::COUNTER_WIDTH_DEFAULT,
   parameter int PAIR_COUNT    = cpwm_pkg::PAIR_COUNT_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic                                   req_mode,
   input  wire logic [cpwm_pkg::PERCENT_WIDTH-1:0]     req_duty_percent,
   input  wire logic [cpwm_pkg::MASK_WIDTH-1:0]        req_pair_mask,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic      [cpwm_pkg::LEVEL_WIDTH-1:0]       rsp_channel_levels,
   output logic      [cpwm_pkg::OUT_CNT_WIDTH-1:0]     rsp_counter_value,
   output logic                                        rsp_reload_done,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [cpwm_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [cpwm_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);
   import cpwm_pkg::*;

   localparam int CMP_WIDTH = (COUNTER_WIDTH > TOP_WIDTH) ? COUNTER_WIDTH : TOP_WIDTH;

   logic [TOP_WIDTH-1:0]      period_top_ff;
   logic [TOP_WIDTH-1:0]      counter_start_ff;
   logic [PRESCALE_WIDTH-1:0] clock_prescale_ff;
   logic [DT_CODE_WIDTH-1:0]  dt_prescale_ff;
   logic [DT_VALUE_WIDTH-1:0] dt_value_ff;

   logic                     in_valid_ff;
   logic                     in_mode_ff;
   logic [PRODUCT_WIDTH-1:0] in_product_ff;
   logic [MASK_WIDTH-1:0]    in_mask_ff;

   logic                     rsp_valid_ff;
   logic [LEVEL_WIDTH-1:0]   rsp_levels_ff;
   logic [OUT_CNT_WIDTH-1:0] rsp_counter_ff;
   logic                     rsp_reload_ff;

   logic [COUNTER_WIDTH-1:0] counter_ff, counter_in;
   logic [DIVIDER_WIDTH-1:0] divider_ff, divider_in;
   logic                     pending_ff, pending_in;

   logic                     accept;
   logic                     fire;
   logic                     tick;
   logic                     reload_in;
   logic [PERCENT_WIDTH-1:0] percent_sat;
   logic [PRODUCT_WIDTH-1:0] product_in;
   logic [QUOT_WIDTH-1:0]    quot_full;
   logic [COUNTER_WIDTH-1:0] match_in;
   logic [DIVIDER_WIDTH:0]   limit_full;
   logic [DIVIDER_WIDTH-1:0] limit;
   pair_ctrl_type            pair_ctrl;
   logic [2*PAIR_COUNT-1:0]  pair_levels;
   logic [LEVEL_WIDTH-1:0]   levels_in;

   assign csr_ready = 1'b1;
   assign fire      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign accept    = req_valid && !req_stall;
   assign tick      = fire && !in_mode_ff;

   assign percent_sat = (req_duty_percent > DUTY_MAX) ? DUTY_MAX : req_duty_percent;
   assign product_in  = PRODUCT_WIDTH'(percent_sat) * PRODUCT_WIDTH'(period_top_ff);
   assign quot_full   = QUOT_WIDTH'(in_product_ff) * QUOT_WIDTH'(DIV100_RECIP);
   assign match_in    = COUNTER_WIDTH'(quot_full[RECIP_SHIFT +: OUT_CNT_WIDTH]);

   assign limit_full = (DIVIDER_WIDTH+1)'(1) << clock_prescale_ff;
   assign limit      = DIVIDER_WIDTH'(limit_full - (DIVIDER_WIDTH+1)'(1));

   always_comb begin
      counter_in = counter_ff;
      divider_in = divider_ff;
      pending_in = pending_ff;
      reload_in  = 1'b0;
      if (fire && in_mode_ff) begin
         pending_in = 1'b1;
      end else if (tick) begin
         if (divider_ff >= limit) begin
            divider_in = '0;
            if (CMP_WIDTH'(counter_ff) >= CMP_WIDTH'(period_top_ff)) begin
               counter_in = COUNTER_WIDTH'(counter_start_ff);
               if (pending_ff) begin
                  pending_in = 1'b0;
                  reload_in  = 1'b1;
               end
            end else begin
               counter_in = counter_ff + COUNTER_WIDTH'(1);
            end
         end else begin
            divider_in = divider_ff + DIVIDER_WIDTH'(1);
         end
      end
   end

   assign pair_ctrl.tick       = tick;
   assign pair_ctrl.reload     = reload_in;
   assign pair_ctrl.dead_ticks = dead_ticks_of(dt_prescale_ff, dt_value_ff);

   for (genvar k = 0; k < PAIR_COUNT; k++) begin : g_pair
      logic write_en;
      if (k < MASK_WIDTH) begin : g_write
         assign write_en = fire && in_mode_ff && in_mask_ff[k];
      end else begin : g_nowrite
         assign write_en = 1'b0;
      end
      cpwm_pair #(
         .COUNTER_WIDTH (COUNTER_WIDTH)
      ) u_pair (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (pair_ctrl),
         .write_en    (write_en),
         .write_match (match_in),
         .counter_in  (counter_in),
         .level_in    (pair_levels[2*k +: 2])
      );
   end

   for (genvar k = 0; k < LEVEL_PAIRS; k++) begin : g_level
      if (k < PAIR_COUNT) begin : g_used
         assign levels_in[2*k +: 2] = pair_levels[2*k +: 2];
      end else begin : g_unused
         assign levels_in[2*k +: 2] = 2'b00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_top_ff     <= PERIOD_TOP_RESET;
         counter_start_ff  <= COUNTER_START_RESET;
         clock_prescale_ff <= CLOCK_PRESCALE_RESET;
         dt_prescale_ff    <= DT_PRESCALE_RESET;
         dt_value_ff       <= DT_VALUE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PERIOD_TOP:        period_top_ff     <= csr_data;
            CSR_COUNTER_START:     counter_start_ff  <= csr_data;
            CSR_CLOCK_PRESCALE:    clock_prescale_ff <= csr_data[PRESCALE_WIDTH-1:0];
            CSR_DEADTIME_PRESCALE: dt_prescale_ff    <= csr_data[DT_CODE_WIDTH-1:0];
            CSR_DEADTIME_VALUE:    dt_value_ff       <= csr_data[DT_VALUE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= COUNTER_WIDTH'(COUNTER_START_RESET);
         divider_ff <= '0;
         pending_ff <= 1'b0;
      end else begin
         counter_ff <= counter_in;
         divider_ff <= divider_in;
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_mode_ff    <= req_mode;
         in_product_ff <= product_in;
         in_mask_ff    <= req_pair_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_levels_ff  <= levels_in;
         rsp_counter_ff <= OUT_CNT_WIDTH'(counter_in);
         rsp_reload_ff  <= reload_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_channel_levels = rsp_levels_ff;
   assign rsp_counter_value  = rsp_counter_ff;
   assign rsp_reload_done    = rsp_reload_ff;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled without a blocked beat in the input register");

   a_reload_clears_pending: assert property (@(posedge clock) disable iff (reset)
      (tick && reload_in) |=> !pending_ff)
      else $error("pending load survived a reload");

   a_pair_never_both_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_levels_ff & (rsp_levels_ff >> 1) & 8'h55) == 8'h00))
      else $error("both channels of a pair driven high");

endmodule

`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import cpwm_pkg::*;

   localparam logic MODE_TICK = 1'b0;
   localparam logic MODE_DUTY = 1'b1;

   typedef struct {
      logic                     mode;
      logic [PERCENT_WIDTH-1:0] percent;
      logic [MASK_WIDTH-1:0]    mask;
   } pwm_beat_type;

   typedef struct {
      logic [LEVEL_WIDTH-1:0]   levels;
      logic [OUT_CNT_WIDTH-1:0] counter;
      logic                     reload;
   } pwm_levels_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic                       req_mode = MODE_TICK;
   logic [PERCENT_WIDTH-1:0]   req_duty_percent = '0;
   logic [MASK_WIDTH-1:0]      req_pair_mask = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [LEVEL_WIDTH-1:0]     rsp_channel_levels;
   logic [OUT_CNT_WIDTH-1:0]   rsp_counter_value;
   logic                       rsp_reload_done;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data = '0;

   complementary_pwm_deadtime_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_duty_percent   (req_duty_percent),
      .req_pair_mask      (req_pair_mask),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_channel_levels (rsp_channel_levels),
      .rsp_counter_value  (rsp_counter_value),
      .rsp_reload_done    (rsp_reload_done),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #4 clock = ~clock;

   // Timer configuration as the predictor sees it.
   logic [TOP_WIDTH-1:0]      cfg_top;
   logic [TOP_WIDTH-1:0]      cfg_start;
   logic [PRESCALE_WIDTH-1:0] cfg_clk_pre;
   logic [DT_CODE_WIDTH-1:0]  cfg_dt_code;
   logic [DT_VALUE_WIDTH-1:0] cfg_dt_value;

   // Predicted timer state.
   logic [OUT_CNT_WIDTH-1:0]  pred_cnt;
   logic [DIVIDER_WIDTH-1:0]  pred_div;
   logic [OUT_CNT_WIDTH-1:0]  pred_active [LEVEL_PAIRS];
   logic [OUT_CNT_WIDTH-1:0]  pred_shadow [LEVEL_PAIRS];
   logic                      pred_armed;
   logic                      pred_raw [LEVEL_PAIRS];
   logic [DEAD_WIDTH-1:0]     pred_blank [LEVEL_PAIRS];

   pwm_beat_type   beats_pending [$];
   pwm_levels_type levels_due [$];
   pwm_beat_type   next_beat;
   pwm_levels_type due_head;

   int  fail_count = 0;
   int  rsp_beats = 0;
   int  req_idle_left = 0;
   int  stall_left = 0;
   int  hold_left = 0;
   int  next_hold_at = 300;
   bit  gaps_on = 1'b1;
   bit  stalls_on = 1'b1;

   task automatic flag_mismatch(input string what, input int unsigned got,
                                input int unsigned want);
      if (fail_count < 40)
         $display("%0t: mismatch on %s, got %0h, expected %0h", $time, what, got, want);
      fail_count++;
   endtask

   task automatic reset_prediction();
      cfg_top      = PERIOD_TOP_RESET;
      cfg_start    = COUNTER_START_RESET;
      cfg_clk_pre  = CLOCK_PRESCALE_RESET;
      cfg_dt_code  = DT_PRESCALE_RESET;
      cfg_dt_value = DT_VALUE_RESET;
      pred_cnt     = COUNTER_START_RESET;
      pred_div     = '0;
      pred_armed   = 1'b0;
      for (int k = 0; k < LEVEL_PAIRS; k++) begin
         pred_active[k] = '0;
         pred_shadow[k] = '0;
         pred_raw[k]    = 1'b0;
         pred_blank[k]  = '0;
      end
   endtask

   task automatic apply_csr(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      case (idx)
         CSR_PERIOD_TOP:        cfg_top      = data;
         CSR_COUNTER_START:     cfg_start    = data;
         CSR_CLOCK_PRESCALE:    cfg_clk_pre  = data[PRESCALE_WIDTH-1:0];
         CSR_DEADTIME_PRESCALE: cfg_dt_code  = data[DT_CODE_WIDTH-1:0];
         CSR_DEADTIME_VALUE:    cfg_dt_value = data[DT_VALUE_WIDTH-1:0];
         default: ;
      endcase
   endtask

   function automatic logic [DEAD_WIDTH-1:0] blanking_ticks();
      logic [DEAD_WIDTH-1:0] ticks;
      ticks = DEAD_WIDTH'(cfg_dt_value);
      if (cfg_dt_code == DT_CODE_X4)
         ticks = ticks << 2;
      else if (cfg_dt_code == DT_CODE_X16)
         ticks = ticks << 4;
      return ticks;
   endfunction

   // Advances the predicted timer by one accepted beat and records the levels it should show.
   task automatic step_pwm(input logic mode, input logic [PERCENT_WIDTH-1:0] percent,
                           input logic [MASK_WIDTH-1:0] mask);
      pwm_levels_type        r;
      logic [PERCENT_WIDTH-1:0] duty;
      logic [OUT_CNT_WIDTH-1:0] match;
      logic [DEAD_WIDTH-1:0] blank;
      logic [7:0]            div_limit;
      logic                  lv;
      r.reload = 1'b0;
      if (mode == MODE_DUTY) begin
         duty = (percent > DUTY_MAX) ? DUTY_MAX : percent;
         match = OUT_CNT_WIDTH'((32'(duty) * 32'(cfg_top)) / 100);
         for (int k = 0; k < LEVEL_PAIRS; k++)
            if (mask[k])
               pred_shadow[k] = match;
         pred_armed = 1'b1;
      end else begin
         div_limit = (8'd1 << cfg_clk_pre) - 8'd1;
         blank = blanking_ticks();
         if (pred_div >= div_limit) begin
            pred_div = '0;
            if (pred_cnt >= cfg_top) begin
               pred_cnt = cfg_start;
               if (pred_armed) begin
                  pred_active = pred_shadow;
                  pred_armed = 1'b0;
                  r.reload = 1'b1;
               end
            end else begin
               pred_cnt = pred_cnt + 1'b1;
            end
         end else begin
            pred_div = pred_div + 1'b1;
         end
         for (int k = 0; k < LEVEL_PAIRS; k++) begin
            lv = (pred_cnt >= pred_active[k]);
            if (lv != pred_raw[k]) begin
               pred_raw[k] = lv;
               pred_blank[k] = blank;
            end else if (pred_blank[k] != 0) begin
               pred_blank[k] = pred_blank[k] - 1'b1;
            end
         end
      end
      r.levels = '0;
      for (int k = 0; k < LEVEL_PAIRS; k++)
         if (pred_blank[k] == 0)
            r.levels[2 * k + (pred_raw[k] ? 0 : 1)] = 1'b1;
      r.counter = pred_cnt;
      levels_due.push_back(r);
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 60)
         return 0;
      if (r < 88)
         return $urandom_range(3, 1);
      if (r < 97)
         return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            step_pwm(req_mode, req_duty_percent, req_pair_mask);
         if (!req_valid || !req_stall) begin
            if (req_idle_left > 0) begin
               req_idle_left--;
               req_valid <= 1'b0;
            end else if (beats_pending.size() != 0) begin
               next_beat = beats_pending.pop_front();
               req_valid <= 1'b1;
               req_mode <= next_beat.mode;
               req_duty_percent <= next_beat.percent;
               req_pair_mask <= next_beat.mask;
               req_idle_left = gaps_on ? pick_gap() : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // The long hold lets the block fill up and push back on the sender.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (rsp_beats >= next_hold_at) begin
         hold_left = 150;
         next_hold_at = next_hold_at + 450;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (stalls_on && $urandom_range(99) < 30) begin
         stall_left = pick_gap();
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_beats <= rsp_beats + 1;
         if (levels_due.size() == 0) begin
            flag_mismatch("unexpected beat", rsp_channel_levels, 0);
         end else begin
            due_head = levels_due.pop_front();
            if (rsp_channel_levels !== due_head.levels)
               flag_mismatch("channel_levels", rsp_channel_levels, due_head.levels);
            if (rsp_counter_value !== due_head.counter)
               flag_mismatch("counter_value", rsp_counter_value, due_head.counter);
            if (rsp_reload_done !== due_head.reload)
               flag_mismatch("reload_done", rsp_reload_done, due_head.reload);
         end
      end
   end

   task automatic queue_beat(input logic mode, input int percent, input int mask);
      pwm_beat_type b;
      b.mode = mode;
      b.percent = PERCENT_WIDTH'(percent);
      b.mask = MASK_WIDTH'(mask);
      beats_pending.push_back(b);
   endtask

   task automatic queue_random(input int count);
      int pick;
      int percent;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 12)
            percent = 0;
         else if (pick < 24)
            percent = 100;
         else if (pick < 35)
            percent = $urandom_range(127, 101);
         else
            percent = $urandom_range(100);
         queue_beat(($urandom_range(99) < 22) ? MODE_DUTY : MODE_TICK, percent,
                    $urandom_range(15));
      end
   endtask

   task automatic wait_idle();
      do
         @(posedge clock);
      while (beats_pending.size() != 0 || req_valid || levels_due.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      apply_csr(idx, data);
   endtask

   task automatic set_timer(input int top, input int start, input int clk_pre,
                            input int dt_code, input int dt_value);
      write_csr(CSR_PERIOD_TOP, CSR_DATA_WIDTH'(top));
      write_csr(CSR_COUNTER_START, CSR_DATA_WIDTH'(start));
      write_csr(CSR_CLOCK_PRESCALE, CSR_DATA_WIDTH'(clk_pre));
      write_csr(CSR_DEADTIME_PRESCALE, CSR_DATA_WIDTH'(dt_code));
      write_csr(CSR_DEADTIME_VALUE, CSR_DATA_WIDTH'(dt_value));
      csr_valid <= 1'b0;
   endtask

   initial begin
      int top;
      reset_prediction();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      queue_beat(MODE_TICK, 127, 15);
      queue_beat(MODE_DUTY, 127, 15);
      queue_beat(MODE_DUTY, 0, 1);
      queue_beat(MODE_DUTY, 50, 2);
      queue_beat(MODE_DUTY, 101, 4);
      queue_beat(MODE_DUTY, 100, 8);
      queue_beat(MODE_DUTY, 85, 10);
      queue_beat(MODE_DUTY, 42, 5);
      queue_beat(MODE_DUTY, 25, 0);
      for (int i = 0; i < 12; i++)
         queue_beat(MODE_TICK, 0, 0);
      wait_idle();

      set_timer(20, 0, 0, 0, 2);
      gaps_on = 1'b0;
      stalls_on = 1'b0;
      queue_random(200);
      wait_idle();

      set_timer(30, 5, 1, 2, 1);
      gaps_on = 1'b1;
      stalls_on = 1'b1;
      queue_random(200);
      wait_idle();

      set_timer(12, 3, 0, 1, 0);
      queue_random(150);
      wait_idle();

      set_timer(10, 40, 0, 3, 63);
      gaps_on = 1'b0;
      queue_random(80);
      wait_idle();

      set_timer(0, 0, 0, 0, 1);
      gaps_on = 1'b1;
      queue_random(40);
      wait_idle();

      set_timer(65535, 65530, 0, 1, 3);
      queue_random(100);
      wait_idle();

      set_timer(8, 0, 7, 0, 5);
      stalls_on = 1'b0;
      queue_random(100);
      wait_idle();

      top = $urandom_range(40, 4);
      set_timer(top, $urandom_range(top - 1), $urandom_range(2), $urandom_range(3),
                $urandom_range(7));
      stalls_on = 1'b1;
      queue_random(250);
      wait_idle();

      repeat (10) @(posedge clock);
      if (levels_due.size() != 0)
         flag_mismatch("beats never returned", 0, levels_due.size());
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #6000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
